>>> rtl/core/ars_pkg.sv
`default_nettype none
package ars_pkg;

  // sample format
  localparam int unsigned SampleBits = 24;
  localparam longint     SampleMax  = (64'sd1 <<< (SampleBits - 1)) - 64'sd1;
  localparam longint     Clip99     = (((SampleMax + 64'sd1) * 64'sd99) + 64'sd50) / 64'sd100;

  // fade and trim constants
  localparam longint     FadeOne   = 64'sd8388608;
  localparam longint     FadeFloor = 64'sd839;
  localparam longint     FadeStep  = 64'sd83886;
  localparam longint     TrimK     = 64'sd85899;
  localparam longint     AvgMax    = (64'sd1 <<< 39) - 64'sd1;

  // register reset values
  localparam logic [15:0] GainReset      = 16'd16384;
  localparam logic [31:0] BaseSpeedReset = 32'd268435456;
  localparam logic [14:0] MinFillReset   = 15'd2880;
  localparam int unsigned RingDepthDef   = 16384;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BLOCK = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } ars_op_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_OVERRUN = 2'd1,
    EV_UNDERRUN = 2'd2,
    EV_RSVD    = 2'd3
  } ars_event_e;

  typedef enum logic [1:0] {
    REG_GAIN      = 2'd0,
    REG_LIMITER   = 2'd1,
    REG_BASE      = 2'd2,
    REG_MIN_FILL  = 2'd3
  } ars_reg_e;

endpackage
`default_nettype wire

>>> rtl/core/ars_if.sv
`default_nettype none
// input item channel
interface ars_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic signed [ars_pkg::SampleBits-1:0] sample_left;
  logic signed [ars_pkg::SampleBits-1:0] sample_right;
  logic [12:0]                        block_length;

  modport source (output valid, operation, sample_left, sample_right, block_length,
                  input ready);
  modport sink   (input valid, operation, sample_left, sample_right, block_length,
                  output ready);
endinterface

// result item channel
interface ars_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ars_pkg::SampleBits-1:0] out_left;
  logic signed [ars_pkg::SampleBits-1:0] out_right;
  logic                               playing;
  logic [1:0]                         ring_event;
  logic [14:0]                        fill_level;

  modport source (output valid, out_left, out_right, playing, ring_event, fill_level,
                  input ready);
  modport sink   (input valid, out_left, out_right, playing, ring_event, fill_level,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/adaptive_ring_resampler_core.sv
`default_nettype none
// Stereo resampling ring buffer. Sample pairs are written with gain and an
// optional 0.99 clip into one RING_DEPTH x 48 bit single-port memory; ticks
// read four neighbors per channel and interpolate with Catmull-Rom, then apply
// gain, fade and clip. Steps of each beat: a write is accepted, written to
// memory and handed off; an op code or a tick of a silent block is accepted
// and handed off; a playing tick does the four memory reads through the one
// port, then the three-step interpolation and the output scaling, then the
// handoff; a block start forms its product and evaluates the fill, and while
// playing adds two reciprocal steps for the error average by 100, two for the
// trim product, then the speed span by 20 and the clamp.
// Unwritten ring entries read as zero through the write count, so no clear
// follows reset. One beat is worked at a time; a finished result waits in the
// output register, and a later result holds off the input until that one is taken.
module adaptive_ring_resampler_core #(
  parameter int unsigned RING_DEPTH = ars_pkg::RingDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ars_in_if.sink           in_ch,
  ars_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ars_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned SB = SampleBits;
  localparam logic signed [32:0] DepthS = 33'(RING_DEPTH);
  // ceil(2^38 / 100), exact for 31 bit dividends
  localparam logic [31:0] Recip100 = 32'd2748779070;
  // ceil(2^33 / 5), exact for 30 bit dividends
  localparam logic [30:0] Recip5 = 31'd1717986919;

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_BPROD, S_BEVAL, S_BDIVH, S_BDIVL, S_BAVG, S_BMULLO, S_BMULHI,
    S_BTRIM, S_BSPEED, S_TREAD, S_TC1, S_TC2, S_TC3, S_TC4, S_TC5,
    S_TC6, S_DONE
  } state_e;

  // truncating signed shift right (division by 2^k toward zero)
  function automatic logic signed [63:0] tshr(input logic signed [63:0] x,
                                              input int unsigned k);
    logic signed [63:0] bias;
    bias = (x < 0) ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  // optional clip then saturation to sample range
  function automatic logic signed [SB-1:0] fin(input logic signed [63:0] v,
                                               input logic lim);
    logic signed [63:0] t;
    t = v;
    if (lim) begin
      if (t > Clip99) t = Clip99;
      if (t < -Clip99) t = -Clip99;
    end
    if (t > SampleMax) t = SampleMax;
    if (t < -SampleMax - 64'sd1) t = -SampleMax - 64'sd1;
    return t[SB-1:0];
  endfunction

  // configuration registers
  logic [15:0] gain_q;
  logic        lim_q;
  logic [31:0] base_q;
  logic [14:0] minf_q;

  assign pready = 1'b1;

  always_comb begin
    unique case (ars_reg_e'(paddr[3:2]))
      REG_GAIN:     prdata = {16'd0, gain_q};
      REG_LIMITER:  prdata = {31'd0, lim_q};
      REG_BASE:     prdata = base_q;
      REG_MIN_FILL: prdata = {17'd0, minf_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      lim_q  <= 1'b0;
      base_q <= BaseSpeedReset;
      minf_q <= MinFillReset;
    end else if (psel && penable && pwrite) begin
      unique case (ars_reg_e'(paddr[3:2]))
        REG_GAIN:     gain_q <= pwdata[15:0];
        REG_LIMITER:  lim_q  <= pwdata[0];
        REG_BASE:     base_q <= pwdata;
        REG_MIN_FILL: minf_q <= pwdata[14:0];
        default:      gain_q <= gain_q;
      endcase
    end
  end

  // state
  state_e             state_q;
  logic [2:0]         cnt_q;
  logic signed [SB-1:0] sl_q, sr_q;
  logic [12:0]        blen_q;
  logic [31:0]        wc_q, rc_q, phase_q, ws_q, speed_q;
  logic signed [39:0] avg_q;
  logic [23:0]        fade_q;
  logic               playing_q, silent_q, wrapped_q;
  logic [44:0]        prod_q;
  logic [47:0]        div_num_q;
  logic [6:0]         div_rem_q;
  logic               div_neg_q;
  logic [31:0]        span_q;
  logic [57:0]        trim_acc_q;
  logic signed [34:0] trim_q;
  logic signed [SB-1:0] tap_l_q [4];
  logic signed [SB-1:0] tap_r_q [4];
  logic signed [29:0] acc_l_q, acc_r_q, c2_l_q, c2_r_q, c3_l_q, c3_r_q;
  logic signed [33:0] g_l_q, g_r_q;
  logic signed [SB-1:0] res_l_q, res_r_q;
  ars_event_e         evt_q;
  logic               out_valid_q;
  logic signed [SB-1:0] out_l_q, out_r_q;
  logic               out_play_q;
  ars_event_e         out_evt_q;
  logic [14:0]        out_fill_q;

  // ring memory, left in the upper half
  logic [2*SB-1:0] ring_mem [RING_DEPTH];
  logic [2*SB-1:0] rd_q;
  logic            rd_valid_q;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic [2*SB-1:0] mem_wdata;
  logic signed [SB-1:0] wl, wr;

  assign wl = fin(tshr(64'(sl_q) * 64'($signed({1'b0, gain_q})), 14), lim_q);
  assign wr = fin(tshr(64'(sr_q) * 64'($signed({1'b0, gain_q})), 14), lim_q);
  assign mem_we    = (state_q == S_WRITE);
  assign mem_wdata = {wl, wr};
  assign mem_addr  = mem_we ? wc_q[AW-1:0] : (rc_q[AW-1:0] + AW'(cnt_q) - AW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_addr] <= mem_wdata;
    rd_q <= ring_mem[mem_addr];
  end

  // block start evaluation
  logic [47:0]        tgt5;
  logic [46:0]        tgt_c, mf;
  logic [18:0]        tgt_int;
  logic [17:0]        min_req;
  logic signed [32:0] avail, avail_eff;
  logic               ovr, und, pl0, pl1;
  logic [31:0]        rc_b;
  logic signed [39:0] avg0;
  logic signed [55:0] raw, num;

  always_comb begin
    tgt5    = (48'(prod_q) << 2) + 48'(prod_q);
    tgt_c   = tgt5[47:1];
    mf      = 47'({minf_q, 28'd0});
    if (mf > tgt_c) tgt_c = mf;
    tgt_int = tgt_c[46:28];
    min_req = 18'(prod_q[44:28]) + 18'd8;
    avail   = 33'($signed(wc_q - rc_q));
    ovr     = (avail > DepthS);
    und     = (avail < 0);
    pl0     = playing_q;
    rc_b    = rc_q;
    avg0    = avg_q;
    avail_eff = avail;
    if (ovr) begin
      pl0 = 1'b0; rc_b = wc_q - 32'(tgt_int); avg0 = '0;
      avail_eff = 33'($signed({1'b0, tgt_int}));
    end else if (und) begin
      pl0 = 1'b0; rc_b = wc_q; avg0 = '0; avail_eff = '0;
    end
    if (!pl0 && avail_eff >= 33'($signed({1'b0, tgt_int}))) pl1 = 1'b1;
    else if (pl0 && avail_eff < 33'($signed({1'b0, min_req}))) pl1 = 1'b0;
    else pl1 = pl0;
    raw = (56'(avail_eff) <<< 20) - 56'($signed({1'b0, tgt_c[46:8]}));
    num = 56'(avg0) * 56'sd99 + raw;
  end

  // reciprocal division by 100 in two 24 bit digits, speed span by 20
  logic [30:0] dv_in;
  logic [63:0] dv_prod;
  logic [23:0] dv_quo;
  logic [6:0]  dv_rem;
  logic [61:0] span_prod;
  logic [31:0] span_val;
  always_comb begin
    dv_in     = (state_q == S_BDIVL) ? {div_rem_q, div_num_q[23:0]}
                                     : {7'd0, div_num_q[47:24]};
    dv_prod   = 64'(dv_in) * 64'(Recip100);
    dv_quo    = dv_prod[61:38];
    dv_rem    = 7'(div_num_q[47:24] - dv_quo * 24'd100);
    span_prod = 62'(base_q[31:2]) * 62'(Recip5);
    span_val  = 32'(span_prod[61:33]);
  end

  // quotient and trim helpers
  logic signed [48:0] quo_s;
  logic signed [48:0] avg_new;
  logic [39:0]        avg_mag;
  logic signed [35:0] spd, sp_lo, sp_hi;
  always_comb begin
    quo_s   = div_neg_q ? -$signed({1'b0, div_num_q}) : $signed({1'b0, div_num_q});
    avg_new = quo_s;
    if (avg_new > 49'(AvgMax)) avg_new = 49'(AvgMax);
    if (avg_new < -49'(AvgMax) - 49'sd1) avg_new = -49'(AvgMax) - 49'sd1;
    avg_mag = (avg_q < 0) ? 40'(-41'(avg_q)) : 40'(avg_q);
    sp_lo   = $signed({4'd0, base_q}) - $signed({4'd0, span_q});
    sp_hi   = $signed({4'd0, base_q}) + $signed({4'd0, span_q});
    spd     = $signed({4'd0, base_q}) + 36'(trim_q);
    if (spd < sp_lo) spd = sp_lo;
    if (spd > sp_hi) spd = sp_hi;
    if (spd > 36'sh0FFFFFFFF) spd = 36'sh0FFFFFFFF;
  end

  // tick helpers
  logic signed [63:0] fsg, fade_s, fade_n;
  logic [36:0]        tot;
  logic               advance, starved;
  logic signed [63:0] y_l, y_r;
  always_comb begin
    fsg    = 64'($signed({1'b0, phase_q[31:16]}));
    fade_s = 64'($signed({1'b0, fade_q}));
    fade_n = fade_s + tshr(((playing_q ? FadeOne : 64'sd0) - fade_s) * FadeStep, 24);
    if (fade_n < 0) fade_n = 64'sd0;
    if (fade_n > FadeOne) fade_n = FadeOne;
    tot     = 37'(phase_q) + {1'b0, speed_q, 4'd0};
    advance = playing_q || (fade_s >= FadeFloor);
    starved = !($signed(ws_q - rc_q) > 32'sd2);
    y_l     = 64'(tap_l_q[1]) + tshr(64'(acc_l_q), 1);
    y_r     = 64'(tap_r_q[1]) + tshr(64'(acc_r_q), 1);
  end

  // fill level after the op
  logic signed [31:0] fdiff;
  logic [31:0]        fill32;
  always_comb begin
    fdiff = $signed(wc_q - rc_q);
    if (fdiff < 0) fill32 = 32'd0;
    else if (fdiff > $signed(32'(RING_DEPTH))) fill32 = 32'(RING_DEPTH);
    else fill32 = fdiff;
  end

  assign in_ch.ready = (state_q == S_IDLE);
  assign out_ch.valid      = out_valid_q;
  assign out_ch.out_left   = out_l_q;
  assign out_ch.out_right  = out_r_q;
  assign out_ch.playing    = out_play_q;
  assign out_ch.ring_event = out_evt_q;
  assign out_ch.fill_level = out_fill_q;

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0;
      wc_q <= '0; rc_q <= '0; phase_q <= '0; ws_q <= '0;
      speed_q <= BaseSpeedReset; avg_q <= '0; fade_q <= '0;
      playing_q <= 1'b0; silent_q <= 1'b1; wrapped_q <= 1'b0;
      out_valid_q <= 1'b0; rd_valid_q <= 1'b0; evt_q <= EV_NONE;
    end else begin
      rd_valid_q <= wrapped_q || (mem_addr < wc_q[AW-1:0]);
      if (out_valid_q && out_ch.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            sl_q <= in_ch.sample_left; sr_q <= in_ch.sample_right;
            blen_q <= in_ch.block_length;
            res_l_q <= '0; res_r_q <= '0; evt_q <= EV_NONE; cnt_q <= '0;
            unique case (ars_op_e'(in_ch.operation))
              OP_WRITE: state_q <= S_WRITE;
              OP_BLOCK: state_q <= S_BPROD;
              OP_TICK:  state_q <= silent_q ? S_DONE : S_TREAD;
              OP_NONE:  state_q <= S_DONE;
              default:  state_q <= S_DONE;
            endcase
          end
        end
        // write beat: memory write is driven combinationally
        S_WRITE: begin
          wc_q <= wc_q + 32'd1;
          if (&wc_q[AW-1:0]) wrapped_q <= 1'b1;
          state_q <= S_DONE;
        end
        // block start
        S_BPROD: begin
          prod_q  <= 45'(blen_q) * 45'(base_q);
          state_q <= S_BEVAL;
        end
        S_BEVAL: begin
          if (ovr) evt_q <= EV_OVERRUN;
          else if (und) evt_q <= EV_UNDERRUN;
          if (ovr || und) phase_q <= '0;
          rc_q <= rc_b; avg_q <= avg0; playing_q <= pl1; ws_q <= wc_q;
          silent_q <= !pl1 && (fade_s < FadeFloor);
          if (pl1) begin
            div_neg_q <= (num < 0);
            div_num_q <= (num < 0) ? 48'(-num) : 48'(num);
            state_q <= S_BDIVH;
          end else begin
            speed_q <= base_q;
            state_q <= S_DONE;
          end
        end
        // upper quotient digit, remainder carried down
        S_BDIVH: begin
          div_num_q[47:24] <= dv_quo;
          div_rem_q        <= dv_rem;
          state_q          <= S_BDIVL;
        end
        S_BDIVL: begin
          div_num_q[23:0] <= dv_quo;
          state_q         <= S_BAVG;
        end
        S_BAVG: begin
          avg_q   <= avg_new[39:0];
          state_q <= S_BMULLO;
        end
        S_BMULLO: begin
          trim_acc_q <= 58'(avg_mag[19:0]) * 58'(TrimK);
          state_q    <= S_BMULHI;
        end
        S_BMULHI: begin
          trim_acc_q <= trim_acc_q + ((58'(avg_mag[39:20]) * 58'(TrimK)) << 20);
          state_q    <= S_BTRIM;
        end
        S_BTRIM: begin
          trim_q <= (avg_q < 0) ? -$signed({1'b0, trim_acc_q[57:24]})
                                : $signed({1'b0, trim_acc_q[57:24]});
          span_q  <= span_val;
          state_q <= S_BSPEED;
        end
        S_BSPEED: begin
          speed_q <= spd[31:0];
          state_q <= S_DONE;
        end
        // tick: four reads through the memory port, fade update on the first
        S_TREAD: begin
          if (cnt_q == 3'd0) fade_q <= fade_n[23:0];
          if (cnt_q != 3'd0) begin
            tap_l_q[cnt_q[1:0] - 2'd1] <= rd_valid_q ? rd_q[2*SB-1:SB] : '0;
            tap_r_q[cnt_q[1:0] - 2'd1] <= rd_valid_q ? rd_q[SB-1:0] : '0;
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) state_q <= S_TC1;
        end
        S_TC1: begin
          acc_l_q <= 30'(tap_l_q[3]) - 30'(tap_l_q[0])
                   + 30'sd3 * (30'(tap_l_q[1]) - 30'(tap_l_q[2]));
          acc_r_q <= 30'(tap_r_q[3]) - 30'(tap_r_q[0])
                   + 30'sd3 * (30'(tap_r_q[1]) - 30'(tap_r_q[2]));
          c2_l_q <= 30'sd2 * 30'(tap_l_q[0]) - 30'sd5 * 30'(tap_l_q[1])
                  + 30'sd4 * 30'(tap_l_q[2]) - 30'(tap_l_q[3]);
          c2_r_q <= 30'sd2 * 30'(tap_r_q[0]) - 30'sd5 * 30'(tap_r_q[1])
                  + 30'sd4 * 30'(tap_r_q[2]) - 30'(tap_r_q[3]);
          c3_l_q <= 30'(tap_l_q[2]) - 30'(tap_l_q[0]);
          c3_r_q <= 30'(tap_r_q[2]) - 30'(tap_r_q[0]);
          state_q <= S_TC2;
        end
        S_TC2: begin
          acc_l_q <= 30'(tshr(64'(acc_l_q) * fsg, 16)) + c2_l_q;
          acc_r_q <= 30'(tshr(64'(acc_r_q) * fsg, 16)) + c2_r_q;
          state_q <= S_TC3;
        end
        S_TC3: begin
          acc_l_q <= 30'(tshr(64'(acc_l_q) * fsg, 16)) + c3_l_q;
          acc_r_q <= 30'(tshr(64'(acc_r_q) * fsg, 16)) + c3_r_q;
          state_q <= S_TC4;
        end
        S_TC4: begin
          acc_l_q <= 30'(tshr(64'(acc_l_q) * fsg, 16));
          acc_r_q <= 30'(tshr(64'(acc_r_q) * fsg, 16));
          state_q <= S_TC5;
        end
        S_TC5: begin
          g_l_q <= 34'(tshr(y_l * 64'($signed({1'b0, gain_q})), 14));
          g_r_q <= 34'(tshr(y_r * 64'($signed({1'b0, gain_q})), 14));
          state_q <= S_TC6;
        end
        S_TC6: begin
          res_l_q <= fin(tshr(64'(g_l_q) * fade_s, 23), lim_q);
          res_r_q <= fin(tshr(64'(g_r_q) * fade_s, 23), lim_q);
          if (advance) begin
            if (!starved) begin
              rc_q    <= rc_q + 32'(tot[36:32]);
              phase_q <= tot[31:0];
            end else begin
              fade_q <= fade_q >> 1;
            end
          end
          state_q <= S_DONE;
        end
        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_l_q     <= res_l_q;
            out_r_q     <= res_r_q;
            out_play_q  <= playing_q;
            out_evt_q   <= evt_q;
            out_fill_q  <= fill32[14:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
